### hdl/qct_pkg.sv
`timescale 1ns / 1ps

package qct_pkg;

    localparam int CHAR_WIDTH = 16;
    localparam int OUT_WIDTH  = 16;
    localparam int MAX_RES    = 3;

    localparam logic [OUT_WIDTH-1:0] CHAR_MASK =
        (CHAR_WIDTH >= OUT_WIDTH) ? {OUT_WIDTH{1'b1}}
                                  : OUT_WIDTH'((64'd1 << CHAR_WIDTH) - 64'd1);

    localparam logic [OUT_WIDTH-1:0] CH_SPACE = OUT_WIDTH'(8'h20);
    localparam logic [OUT_WIDTH-1:0] CH_TAB   = OUT_WIDTH'(8'h09);
    localparam logic [OUT_WIDTH-1:0] CH_CR    = OUT_WIDTH'(8'h0D);
    localparam logic [OUT_WIDTH-1:0] CH_LF    = OUT_WIDTH'(8'h0A);
    localparam logic [OUT_WIDTH-1:0] CH_QUOTE = OUT_WIDTH'(8'h22);

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_TOK_END = 2'd1;
    localparam logic [1:0] KIND_CMD_END = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNCLOSED  = 2'd1;
    localparam logic [1:0] ST_EMPTY_PRG = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    typedef struct packed {
        logic in_token;
        logic in_quotes;
        logic quote_pending;
        logic token_seen;
        logic first_token_empty;
        logic token_has_chars;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [OUT_WIDTH-1:0] out_char;
        logic [1:0]           status;
        logic                 run_last;
    } result_t;

endpackage

### hdl/qct_if.sv
`timescale 1ns / 1ps

interface qct_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [qct_pkg::OUT_WIDTH-1:0] ch;
    logic                          last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface qct_tok_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [qct_pkg::OUT_WIDTH-1:0] out_char;
    logic [1:0]                    status;
    logic                          run_last;

    modport source (output valid, output kind, output out_char, output status,
                    output run_last, input ready);
    modport sink (input valid, input kind, input out_char, input status,
                  input run_last, output ready);
endinterface

### hdl/qct_step.sv
`timescale 1ns / 1ps

// Per-character parse decision: next flag state plus up to three results.
module qct_step
(
    input  qct_pkg::parse_state_t                   st,
    input  logic [qct_pkg::OUT_WIDTH-1:0]           ch,
    input  logic                                    last,
    output qct_pkg::parse_state_t                   st_next,
    output qct_pkg::result_t [qct_pkg::MAX_RES-1:0] res,
    output logic [1:0]                              res_cnt
);

    always_comb
    begin
        logic [qct_pkg::OUT_WIDTH-1:0] c;
        logic                          done;
        logic                          is_sep;
        logic                          unclosed;
        logic [1:0]                    n;
        logic [1:0]                    status;
        qct_pkg::parse_state_t         s;
        qct_pkg::result_t [qct_pkg::MAX_RES-1:0] r;

        c        = ch & qct_pkg::CHAR_MASK;
        s        = st;
        done     = 1'b0;
        n        = 2'd0;
        unclosed = 1'b0;
        status   = qct_pkg::ST_OK;
        r        = '0;
        is_sep   = (c == qct_pkg::CH_SPACE) || (c == qct_pkg::CH_TAB) ||
                   (c == qct_pkg::CH_CR) || (c == qct_pkg::CH_LF);

        // quote inside a span: literal quote or closing quote
        if (s.quote_pending)
        begin
            s.quote_pending = 1'b0;
            if (c == qct_pkg::CH_QUOTE)
            begin
                r[n].kind         = qct_pkg::KIND_CHAR;
                r[n].out_char     = qct_pkg::CH_QUOTE;
                n                 = n + 2'd1;
                s.token_has_chars = 1'b1;
                done              = 1'b1;
            end
            else
            begin
                s.in_quotes = 1'b0;
            end
        end

        if (!done)
        begin
            if (is_sep && !s.in_quotes)
            begin
                if (s.in_token)
                begin
                    r[n].kind = qct_pkg::KIND_TOK_END;
                    n         = n + 2'd1;
                    if (!s.token_seen)
                    begin
                        s.first_token_empty = !s.token_has_chars;
                        s.token_seen        = 1'b1;
                    end
                    s.in_token        = 1'b0;
                    s.token_has_chars = 1'b0;
                end
            end
            else
            begin
                s.in_token = 1'b1;
                if (c == qct_pkg::CH_QUOTE)
                begin
                    if (!s.in_quotes)
                        s.in_quotes = 1'b1;
                    else
                        s.quote_pending = 1'b1;
                end
                else
                begin
                    r[n].kind         = qct_pkg::KIND_CHAR;
                    r[n].out_char     = c;
                    n                 = n + 2'd1;
                    s.token_has_chars = 1'b1;
                end
            end
        end

        if (last)
        begin
            if (s.quote_pending)
            begin
                s.quote_pending = 1'b0;
                s.in_quotes     = 1'b0;
            end
            unclosed = s.in_quotes;
            if (s.in_token)
            begin
                r[n].kind = qct_pkg::KIND_TOK_END;
                n         = n + 2'd1;
                if (!s.token_seen)
                begin
                    s.first_token_empty = !s.token_has_chars;
                    s.token_seen        = 1'b1;
                end
            end
            priority if (unclosed)
                status = qct_pkg::ST_UNCLOSED;
            else if (!s.token_seen)
                status = qct_pkg::ST_NONE;
            else if (s.first_token_empty)
                status = qct_pkg::ST_EMPTY_PRG;
            else
                status = qct_pkg::ST_OK;
            r[n].kind   = qct_pkg::KIND_CMD_END;
            r[n].status = status;
            n           = n + 2'd1;
            s           = '0;
        end

        if (n != 2'd0)
            r[n - 2'd1].run_last = 1'b1;

        st_next = s;
        res     = r;
        res_cnt = n;
    end

endmodule

### hdl/quoted_command_tokenizer_unit.sv
`timescale 1ns / 1ps

// Command-line tokenizer. Characters arrive on cmd, one per transaction, with
// last set on the final character of a command; token characters, token ends
// and one end-of-command result with its status leave on tok, in order. Each
// character is decided in the cycle it is taken, from six flag bits, and its
// results (zero to three) are loaded into a three-entry result buffer that
// drains one result per cycle while tok is ready. The next character is taken
// once the buffer is empty or its last result is leaving, so a character with
// several results holds cmd off until all but the last have left through the
// single tok port. Results are dropped by the consumer unless the status on
// the end-of-command result is ok.
module quoted_command_tokenizer_unit
(
    input  logic         clk,
    input  logic         rst_n,
    qct_cmd_if.sink      cmd,
    qct_tok_if.source    tok
);

    qct_pkg::parse_state_t                   state_reg;
    qct_pkg::parse_state_t                   state_next;
    qct_pkg::result_t [qct_pkg::MAX_RES-1:0] slot_reg;
    qct_pkg::result_t [qct_pkg::MAX_RES-1:0] slot_next;
    logic [1:0]                              cnt_reg;
    logic [1:0]                              cnt_next;

    qct_pkg::parse_state_t                   step_state;
    qct_pkg::result_t [qct_pkg::MAX_RES-1:0] step_res;
    logic [1:0]                              step_cnt;

    logic accept;
    logic out_fire;

    qct_step u_step
    (
        .st      (state_reg),
        .ch      (cmd.ch),
        .last    (cmd.last),
        .st_next (step_state),
        .res     (step_res),
        .res_cnt (step_cnt)
    );

    assign out_fire  = tok.valid && tok.ready;
    // take a character once the buffer empties this cycle
    assign cmd.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && tok.ready);
    assign accept    = cmd.valid && cmd.ready;

    assign tok.valid    = (cnt_reg != 2'd0);
    assign tok.kind     = slot_reg[0].kind;
    assign tok.out_char = slot_reg[0].out_char;
    assign tok.status   = slot_reg[0].status;
    assign tok.run_last = slot_reg[0].run_last;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        cnt_next   = cnt_reg;
        priority if (accept)
        begin
            state_next = step_state;
            slot_next  = step_res;
            cnt_next   = step_cnt;
        end
        else if (out_fire)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

### hdl/qct_checker.sv
`timescale 1ns / 1ps

module qct_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          tok_valid,
    input logic                          tok_ready,
    input logic [1:0]                    tok_kind,
    input logic [qct_pkg::OUT_WIDTH-1:0] tok_out_char,
    input logic [1:0]                    tok_status,
    input logic                          tok_run_last
);

    // a stalled result stays presented
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) &&
        $stable(tok_out_char) && $stable(tok_status) && $stable(tok_run_last))
        else $error("tok result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_kind != 2'd3)
        else $error("tok kind out of range");

    // status is only carried by the end-of-command result
    a_status_cmd_end: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_kind != qct_pkg::KIND_CMD_END |-> tok_status == qct_pkg::ST_OK)
        else $error("status on a non command-end result");

    a_cmd_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_kind == qct_pkg::KIND_CMD_END |-> tok_run_last)
        else $error("command end is not the last result of its character");

    // more results of the same character pending: no new character taken
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_run_last |-> !cmd_ready)
        else $error("character taken while earlier results still pending");

endmodule

bind quoted_command_tokenizer_unit qct_checker u_qct_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .tok_valid    (tok.valid),
    .tok_ready    (tok.ready),
    .tok_kind     (tok.kind),
    .tok_out_char (tok.out_char),
    .tok_status   (tok.status),
    .tok_run_last (tok.run_last)
);
